### hdl/lru_cache_tag_lookup_macros.svh
// Assertion macros shared by the lookup controller and datapath.
// Each macro expects a clk and rst in the scope where it is used.
`ifndef LRU_CACHE_TAG_LOOKUP_MACROS_SVH
`define LRU_CACHE_TAG_LOOKUP_MACROS_SVH

// cond must hold at every clock edge out of reset
`define LRUTAG_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define LRUTAG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define LRUTAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/lrutag_pkg.sv
// Shared types and constants for the LRU tag lookup block.
// No dependencies; used by the controller, datapath and top level.
package lrutag_pkg;

  localparam int ADDR_W  = 16;
  localparam int TAG_LSB = 2;
  localparam int TAG_W   = ADDR_W - TAG_LSB;
  localparam int CNT_W   = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic clear;
  } cmd_t;

endpackage

### hdl/lrutag_ctrl.sv
// Sequencing controller for the LRU tag lookup.
// Depends on lrutag_pkg and lru_cache_tag_lookup_macros.svh.
`include "lru_cache_tag_lookup_macros.svh"

module lrutag_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output lrutag_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.clear = cfg_valid && !out_valid;
        if (in_valid && !cfg_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LRUTAG_ASSERT_IMP(a_rise_in_upd, $rose(out_valid), $past(state) == ST_UPDATE, "stray result")
  `LRUTAG_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid, "result dropped")
  `LRUTAG_ASSERT_IMP(a_clear_idle, cmd.clear, !out_valid && state == ST_IDLE, "write in flight")

endmodule

### hdl/lrutag_dp.sv
// Datapath: recency stack cells, parallel tag compare, occupancy and counters.
// Depends on lrutag_pkg and lru_cache_tag_lookup_macros.svh.
`include "lru_cache_tag_lookup_macros.svh"

module lrutag_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lrutag_pkg::cmd_t                  cmd,
  input  logic [lrutag_pkg::ADDR_W-1:0]     address,
  input  logic [lrutag_pkg::CAP_W-1:0]      capacity,
  output logic                              hit,
  output lrutag_pkg::cnt_t                  read_count,
  output lrutag_pkg::cnt_t                  hit_count,
  output lrutag_pkg::cnt_t                  miss_count
);

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (OCC_W > lrutag_pkg::CAP_W) ? OCC_W : lrutag_pkg::CAP_W;

  lrutag_pkg::tag_t                 cells [MAX_ENTRIES];
  lrutag_pkg::tag_t                 tag_q;
  lrutag_pkg::tag_t                 addr_tag;
  logic [MAX_ENTRIES-1:0]           match_d;
  logic [MAX_ENTRIES-1:0]           match_q;
  logic [MAX_ENTRIES-1:0]           shift_en;
  logic [OCC_W-1:0]                 occupancy;
  logic [OCC_W-1:0]                 occupancy_next;
  logic [lrutag_pkg::CAP_W-1:0]     capacity_q;
  logic [CW-1:0]                    cap_ext;
  logic [CW-1:0]                    eff_cap;
  logic                             found;

  assign addr_tag = address[lrutag_pkg::ADDR_W-1:lrutag_pkg::TAG_LSB];
  assign found    = |match_q;

  always_comb begin
    cap_ext = CW'(capacity_q);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    if (found) begin
      occupancy_next = occupancy;
    end else if (CW'(occupancy) >= eff_cap) begin
      occupancy_next = eff_cap[OCC_W-1:0];
    end else begin
      occupancy_next = occupancy + OCC_W'(1);
    end
  end

  assign shift_en[0] = 1'b1;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign match_d[i] = (cells[i] == addr_tag) && (OCC_W'(i) < occupancy);
    if (i > 0) begin : g_shift
      assign shift_en[i] = ~|match_q[i-1:0];
      always_ff @(posedge clk) begin
        if (cmd.commit && shift_en[i]) begin
          cells[i] <= cells[i-1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.commit) begin
          cells[0] <= tag_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_q <= addr_tag;
    end
    if (cmd.commit) begin
      hit <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q    <= '0;
      occupancy  <= '0;
      capacity_q <= lrutag_pkg::CAP_RESET;
      read_count <= '0;
      hit_count  <= '0;
      miss_count <= '0;
    end else if (cmd.clear) begin
      occupancy  <= '0;
      capacity_q <= capacity;
      read_count <= '0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      if (cmd.load) begin
        match_q <= match_d;
      end
      if (cmd.commit) begin
        occupancy <= occupancy_next;
        if (read_count != lrutag_pkg::CNT_MAX) begin
          read_count <= read_count + 32'd1;
        end
        if (found && hit_count != lrutag_pkg::CNT_MAX) begin
          hit_count <= hit_count + 32'd1;
        end
        if (!found && miss_count != lrutag_pkg::CNT_MAX) begin
          miss_count <= miss_count + 32'd1;
        end
      end
    end
  end

  `LRUTAG_ASSERT(a_unique_match, $onehot0(match_q), "tag found in more than one entry")
  `LRUTAG_ASSERT(a_occ_in_cap, CW'(occupancy) <= eff_cap, "occupancy above capacity")
  `LRUTAG_ASSERT_NEXT(a_commit_fills, cmd.commit, occupancy != '0, "empty after lookup")

endmodule

### hdl/lru_cache_tag_lookup.sv
// Fully associative LRU tag directory. The accept cycle of a lookup compares
// the tag against all valid entries in parallel and registers the match
// vector, and the next cycle moves the stack to front and bumps the counters
// into the output register. That update cycle waits while a previous result
// is still stalled, and no new lookup is accepted until it has committed.
// Writing capacity clears entries and counters; the write waits until no
// result is pending and holds off input while offered.
module lru_cache_tag_lookup #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lrutag_pkg::ADDR_W-1:0]     address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [lrutag_pkg::CNT_W-1:0]      read_count,
  output logic [lrutag_pkg::CNT_W-1:0]      hit_count,
  output logic [lrutag_pkg::CNT_W-1:0]      miss_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrutag_pkg::CAP_W-1:0]      capacity
);

  lrutag_pkg::cmd_t cmd;

  lrutag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  lrutag_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .address    (address),
    .capacity   (capacity),
    .hit        (hit),
    .read_count (read_count),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the LRU tag lookup directory.
// Uses lrutag_pkg and the lru_cache_tag_lookup top; predicts hit/miss and counters,
// and checks them under random pacing, output stalls and capacity changes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  typedef struct {
    logic hit;
    lrutag_pkg::cnt_t read_count;
    lrutag_pkg::cnt_t hit_count;
    lrutag_pkg::cnt_t miss_count;
  } lookup_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  class directory_tracker_t;
    logic [lrutag_pkg::CAP_W-1:0] cap_reg;
    lrutag_pkg::tag_t recency[DEPTH];
    int unsigned fill;
    lrutag_pkg::cnt_t reads, hits, misses;
    lookup_t predicted_lookups[$];
    int unsigned faults;
    int unsigned hit_seen, miss_seen;

    function new();
      cap_reg = lrutag_pkg::CAP_RESET;
      clear_all();
    endfunction

    function void clear_all();
      fill = 0;
      reads = '0;
      hits = '0;
      misses = '0;
    endfunction

    function void set_capacity(logic [lrutag_pkg::CAP_W-1:0] v);
      cap_reg = v;
      clear_all();
    endfunction

    function lrutag_pkg::cnt_t bump(lrutag_pkg::cnt_t v);
      return (v == lrutag_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void note_address(logic [lrutag_pkg::ADDR_W-1:0] addr);
      lrutag_pkg::tag_t tag;
      int unsigned cap, pos, last;
      bit found;
      lookup_t res;
      tag = addr[lrutag_pkg::ADDR_W-1:lrutag_pkg::TAG_LSB];
      cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
      found = 0;
      pos = 0;
      for (int i = 0; i < fill; i++) begin
        if (!found && recency[i] == tag) begin
          found = 1;
          pos = i;
        end
      end
      reads = bump(reads);
      if (found) begin
        last = pos;
        hits = bump(hits);
        hit_seen++;
      end else begin
        last = (fill >= cap) ? cap - 1 : fill;
        fill = last + 1;
        misses = bump(misses);
        miss_seen++;
      end
      for (int i = last; i > 0; i--) recency[i] = recency[i-1];
      recency[0] = tag;
      res.hit = found;
      res.read_count = reads;
      res.hit_count = hits;
      res.miss_count = misses;
      predicted_lookups.push_back(res);
    endfunction

    function void check_lookup(logic h, lrutag_pkg::cnt_t rc, lrutag_pkg::cnt_t hc,
                               lrutag_pkg::cnt_t mc);
      lookup_t exp_res;
      if (predicted_lookups.size() == 0) begin
        fault($sformatf("result with no lookup pending: hit=%0b reads=%0d", h, rc));
        return;
      end
      exp_res = predicted_lookups.pop_front();
      if (h !== exp_res.hit)
        fault($sformatf("hit expected %0b got %0b", exp_res.hit, h));
      if (rc !== exp_res.read_count)
        fault($sformatf("read_count expected %0d got %0d", exp_res.read_count, rc));
      if (hc !== exp_res.hit_count)
        fault($sformatf("hit_count expected %0d got %0d", exp_res.hit_count, hc));
      if (mc !== exp_res.miss_count)
        fault($sformatf("miss_count expected %0d got %0d", exp_res.miss_count, mc));
    endfunction

    function int unsigned pending();
      return predicted_lookups.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lrutag_pkg::ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  lrutag_pkg::cnt_t read_count, hit_count, miss_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrutag_pkg::CAP_W-1:0] capacity = lrutag_pkg::CAP_RESET;

  directory_tracker_t tracker = new();
  int unsigned burst_left = 0;
  int unsigned cap_settings = 0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  lru_cache_tag_lookup #(.MAX_ENTRIES(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .address(address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .read_count(read_count),
    .hit_count(hit_count),
    .miss_count(miss_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity(capacity)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_capacity(capacity);
      if (in_valid && !in_stall) tracker.note_address(address);
      if (out_valid && !out_stall) tracker.check_lookup(hit, read_count, hit_count, miss_count);
    end
  end

  initial begin : receiver
    int unsigned cyc;
    int unsigned held;
    stall_mode_t mode;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (held = 0; held < 80; held++) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        cyc++;
        mode = stall_mode_t'((cyc / 97) % 4);
        case (mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cyc[0];
        endcase
      end
    end
  end

  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_lookup(input logic [lrutag_pkg::ADDR_W-1:0] addr);
    pace();
    in_valid <= 1'b1;
    address <= addr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lrutag_pkg::CAP_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_settings++;
  endtask

  task automatic run_phase(input int unsigned n, input logic [lrutag_pkg::CAP_W-1:0] cap);
    lrutag_pkg::tag_t pool[$];
    int unsigned eff, pool_size;
    logic [lrutag_pkg::ADDR_W-1:0] addr;
    write_capacity(cap);
    eff = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : cap);
    pool_size = eff + $urandom_range(0, 3);
    for (int i = 0; i < pool_size; i++) pool.push_back(lrutag_pkg::tag_t'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85)
        addr = {pool[$urandom_range(0, pool_size - 1)], 2'($urandom)};
      else
        addr = lrutag_pkg::ADDR_W'($urandom_range(0, 65535));
      send_lookup(addr);
    end
  endtask

  initial begin : stimulus
    logic [lrutag_pkg::CAP_W-1:0] caps[$];
    caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd2, 5'd8};
    caps.push_back(lrutag_pkg::CAP_W'($urandom_range(0, 31)));
    caps.push_back(lrutag_pkg::CAP_W'($urandom_range(0, 31)));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_lookup(16'h0000);
    send_lookup(16'h0003);
    send_lookup(16'hFFFF);
    send_lookup(16'hFFFC);
    send_lookup(16'h8001);
    send_lookup(16'h7FFE);
    send_lookup(16'h0000);
    write_capacity(5'd1);
    send_lookup(16'h1234);
    send_lookup(16'h1237);
    send_lookup(16'h5678);
    send_lookup(16'h1234);
    write_capacity(5'd0);
    send_lookup(16'hAAAA);
    send_lookup(16'h5555);
    send_lookup(16'h5556);
    write_capacity(5'd2);
    send_lookup(16'h0100);
    send_lookup(16'h0200);
    send_lookup(16'h0101);
    send_lookup(16'h0300);
    send_lookup(16'h0200);

    foreach (caps[i]) begin
      if (i == 0 || i == 5) hold_request = 1'b1;
      run_phase(175, caps[i]);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.fault($sformatf("%0d lookups never produced a result", tracker.pending()));
    $display("Checked %0d lookups (%0d hits, %0d misses) over %0d capacity settings.",
             tracker.hit_seen + tracker.miss_seen, tracker.hit_seen, tracker.miss_seen,
             cap_settings + 1);
    $display("Capacities included 0, 1, 16 and 31; %0d mismatches counted.", tracker.faults);
    if (tracker.faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout waiting for the lookup directory");
    $display("Verification failed");
    $finish;
  end

endmodule
